// ===== design/pga_pkg.sv =====
// Package for the PageRank gather/apply engine.
// Holds the sizes, fixed-point constants, opcodes, item type and sequencer states.
// It depends on no other file.
package pga_pkg;

  localparam int unsigned VTX_COUNT    = 1024;
  localparam int unsigned VTX_W        = $clog2(VTX_COUNT);
  localparam int unsigned DEG_W        = 16;
  localparam int unsigned RANK_W       = 32;
  localparam int unsigned DAMP_W       = 16;
  localparam int unsigned PROD_W       = RANK_W + DAMP_W;
  localparam int unsigned FIFO_DEPTH   = 2;

  localparam logic [RANK_W-1:0] ONE_Q16      = 32'h0001_0000;
  localparam logic [DAMP_W-1:0] DAMP_RESET   = 16'd55706;
  localparam logic [DEG_W-1:0]  DEG_MAX      = {DEG_W{1'b1}};

  typedef enum logic [1:0] {
    OP_COUNT  = 2'd0,
    OP_GATHER = 2'd1,
    OP_APPLY  = 2'd2,
    OP_INIT   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_APPLY
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [VTX_W-1:0] src;
    logic [VTX_W-1:0] dst;
  } item_t;

endpackage

// ===== design/pagerank_gather_apply_engine_core.sv =====
// Top level of the PageRank gather/apply engine: front queue plus back sequencer.
// Depends on pga_pkg, pga_front and pga_back (which uses pga_ram and pga_div).
//
//   channel   handshake               payload
//   input     in_valid_i/in_ready_o   opcode_i, src_vertex_i, dst_vertex_i
//   output    out_valid_o/out_ready_i vertex_id_o, rank_value_o
//   config    cfg_we_i                cfg_wdata_i (damping, Q0.16)
//
// Items are taken from the queue one at a time; a gather with a nonzero degree
// waits on the divider, which makes one quotient bit per cycle.
// After reset a clearing pass over all 1024 vertices fills the stores; no item is
// executed then, though two items queue up in the front.
// A result waiting in the output register stalls only the next apply.
module pagerank_gather_apply_engine_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 opcode_i,
  input  logic [pga_pkg::VTX_W-1:0]  src_vertex_i,
  input  logic [pga_pkg::VTX_W-1:0]  dst_vertex_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [pga_pkg::VTX_W-1:0]  vertex_id_o,
  output logic [pga_pkg::RANK_W-1:0] rank_value_o,
  input  logic                       cfg_we_i,
  input  logic [pga_pkg::DAMP_W-1:0] cfg_wdata_i
);
  import pga_pkg::*;

  logic  q_valid, q_pop;
  item_t q_item;

  pga_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i, .src_vertex_i,
    .dst_vertex_i, .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  pga_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .q_valid_i(q_valid),
    .q_item_i(q_item), .q_pop_o(q_pop), .out_valid_o, .out_ready_i,
    .vertex_id_o, .rank_value_o
  );

  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> !q_pop) else $error("back end took two items in a row");

endmodule

// ===== design/pga_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
// It has no dependencies.
module pga_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/pga_front.sv =====
// Front end: accepts input items and holds them in a short queue for the back end.
// Depends on pga_pkg.
module pga_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            opcode_i,
  input  logic [pga_pkg::VTX_W-1:0] src_vertex_i,
  input  logic [pga_pkg::VTX_W-1:0] dst_vertex_i,
  output logic                  q_valid_o,
  output pga_pkg::item_t        q_item_o,
  input  logic                  q_pop_i
);
  import pga_pkg::*;

  localparam int unsigned PW = $clog2(FIFO_DEPTH);

  item_t         slot_q [FIFO_DEPTH];
  logic [PW-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [PW:0]   cnt_q, cnt_d;
  logic          push, pop;
  item_t         in_item;

  assign in_item.op  = op_e'(opcode_i);
  assign in_item.src = src_vertex_i;
  assign in_item.dst = dst_vertex_i;

  assign in_ready_o = (cnt_q != (PW+1)'(FIFO_DEPTH));
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = slot_q[rd_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    rd_d  = pop  ? PW'(rd_q + 1'b1) : rd_q;
    wr_d  = push ? PW'(wr_q + 1'b1) : wr_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= in_item;
    end
  end

endmodule

// ===== design/pga_div.sv =====
// Radix-2 restoring divider: a rank divided by an out-degree, one quotient bit a cycle.
// Depends on pga_pkg.
module pga_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pga_pkg::RANK_W-1:0] dividend_i,
  input  logic [pga_pkg::DEG_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [pga_pkg::RANK_W-1:0] quot_o
);
  import pga_pkg::*;

  localparam int unsigned CW = $clog2(RANK_W + 1);

  logic [RANK_W-1:0] q_q, q_d;
  logic [DEG_W:0]    rem_q, rem_d;
  logic [DEG_W-1:0]  div_q, div_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [DEG_W:0]    shifted;
  logic              fits;

  assign shifted = {rem_q[DEG_W-1:0], q_q[RANK_W-1]};
  assign fits    = (shifted >= {1'b0, div_q});

  always_comb begin
    q_d    = q_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      q_d   = dividend_i;
      rem_d = '0;
      div_d = divisor_i;
      cnt_d = CW'(RANK_W);
    end else if (cnt_q != '0) begin
      rem_d  = fits ? (shifted - {1'b0, div_q}) : shifted;
      q_d    = {q_q[RANK_W-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

// ===== design/pga_back.sv =====
// Back end: sequencer over the rank, accumulator and out-degree memories.
// Depends on pga_pkg, pga_ram and pga_div.
module pga_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pga_pkg::DAMP_W-1:0] cfg_wdata_i,
  input  logic                       q_valid_i,
  input  pga_pkg::item_t             q_item_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [pga_pkg::VTX_W-1:0]  vertex_id_o,
  output logic [pga_pkg::RANK_W-1:0] rank_value_o
);
  import pga_pkg::*;

  state_e state_q, state_d;
  logic [DAMP_W-1:0] damp_q;
  logic [VTX_W-1:0]  clr_q;
  item_t             cur_q;
  logic [RANK_W-1:0] acc_q;
  logic [PROD_W-1:0] prod_q;
  logic              out_valid_q, out_valid_d;
  logic [VTX_W-1:0]  vid_q;
  logic [RANK_W-1:0] rank_q;

  logic              rank_we, acc_we, deg_we;
  logic [VTX_W-1:0]  rank_wa, acc_wa, deg_wa, rd_src, rd_dst;
  logic [RANK_W-1:0] rank_wd, acc_wd, rank_rd, acc_rd;
  logic [DEG_W-1:0]  deg_wd, deg_rd;
  logic              div_start, div_done;
  logic [RANK_W-1:0] div_quot;
  logic [RANK_W:0]   gsum, asum;
  logic [RANK_W-1:0] gsat, asat;
  logic              out_free;

  assign rd_src   = q_item_i.src;
  assign rd_dst   = q_item_i.dst;
  assign out_free = !out_valid_q || out_ready_i;

  assign gsum = {1'b0, acc_q} + {1'b0, div_quot};
  assign gsat = gsum[RANK_W] ? {RANK_W{1'b1}} : gsum[RANK_W-1:0];
  assign asum = {1'b0, prod_q[PROD_W-1:DAMP_W]}
              + (RANK_W+1)'({1'b0, ONE_Q16} - (RANK_W+1)'(damp_q));
  assign asat = asum[RANK_W] ? {RANK_W{1'b1}} : asum[RANK_W-1:0];

  pga_ram #(.WIDTH(RANK_W), .DEPTH(VTX_COUNT)) u_rank (
    .clk_i, .we_i(rank_we), .waddr_i(rank_wa), .wdata_i(rank_wd),
    .raddr_i(rd_src), .rdata_o(rank_rd)
  );
  pga_ram #(.WIDTH(RANK_W), .DEPTH(VTX_COUNT)) u_acc (
    .clk_i, .we_i(acc_we), .waddr_i(acc_wa), .wdata_i(acc_wd),
    .raddr_i(rd_dst), .rdata_o(acc_rd)
  );
  pga_ram #(.WIDTH(DEG_W), .DEPTH(VTX_COUNT)) u_deg (
    .clk_i, .we_i(deg_we), .waddr_i(deg_wa), .wdata_i(deg_wd),
    .raddr_i(rd_src), .rdata_o(deg_rd)
  );

  pga_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(rank_rd),
    .divisor_i(deg_rd), .done_o(div_done), .quot_o(div_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == VTX_W'(VTX_COUNT - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (q_valid_i) state_d = ST_EXEC;
      ST_EXEC: begin
        unique case (cur_q.op)
          OP_GATHER: state_d = (deg_rd != '0) ? ST_DIV : ST_IDLE;
          OP_APPLY:  state_d = ST_APPLY;
          default:   state_d = ST_IDLE;
        endcase
      end
      ST_DIV:   if (div_done) state_d = ST_IDLE;
      ST_APPLY: if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rank_we     = 1'b0;
    acc_we      = 1'b0;
    deg_we      = 1'b0;
    rank_wa     = cur_q.dst;
    acc_wa      = cur_q.dst;
    deg_wa      = cur_q.src;
    rank_wd     = ONE_Q16;
    acc_wd      = '0;
    deg_wd      = (deg_rd == DEG_MAX) ? deg_rd : DEG_W'(deg_rd + 1'b1);
    div_start   = 1'b0;
    q_pop_o     = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_CLEAR: begin
        rank_we = 1'b1;
        acc_we  = 1'b1;
        deg_we  = 1'b1;
        rank_wa = clr_q;
        acc_wa  = clr_q;
        deg_wa  = clr_q;
        deg_wd  = '0;
      end
      ST_IDLE: q_pop_o = q_valid_i;
      ST_EXEC: begin
        unique case (cur_q.op)
          OP_COUNT:  deg_we = 1'b1;
          OP_GATHER: div_start = (deg_rd != '0);
          OP_INIT: begin
            rank_we = 1'b1;
            acc_we  = 1'b1;
          end
          default: ;
        endcase
      end
      ST_DIV: begin
        acc_we = div_done;
        acc_wd = gsat;
      end
      ST_APPLY: begin
        rank_we = out_free;
        acc_we  = out_free;
        rank_wd = asat;
        if (out_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      damp_q      <= DAMP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_CLEAR) clr_q <= VTX_W'(clr_q + 1'b1);
      if (cfg_we_i) damp_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cur_q <= q_item_i;
    if (state_q == ST_EXEC) begin
      acc_q  <= acc_rd;
      prod_q <= PROD_W'(damp_q) * PROD_W'(acc_rd);
    end
    if (state_q == ST_APPLY && out_free) begin
      vid_q  <= cur_q.dst;
      rank_q <= asat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign vertex_id_o  = vid_q;
  assign rank_value_o = rank_q;

endmodule

// ===== verif/tb_pagerank_gather_apply_engine_core.sv =====
// Testbench for the PageRank gather/apply engine core.
// Drives random and directed items, predicts each rank update and checks it.
// Depends on pga_pkg and pagerank_gather_apply_engine_core.
`timescale 1ns / 1ps

module tb_pagerank_gather_apply_engine_core;
  import pga_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        opcode_i;
  logic [VTX_W-1:0]  src_vertex_i;
  logic [VTX_W-1:0]  dst_vertex_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [VTX_W-1:0]  vertex_id_o;
  logic [RANK_W-1:0] rank_value_o;
  logic              cfg_we_i;
  logic [DAMP_W-1:0] cfg_wdata_i;

  pagerank_gather_apply_engine_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .opcode_i(opcode_i), .src_vertex_i(src_vertex_i), .dst_vertex_i(dst_vertex_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .vertex_id_o(vertex_id_o), .rank_value_o(rank_value_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  typedef struct packed {
    logic [VTX_W-1:0]  vid;
    logic [RANK_W-1:0] rank;
  } rank_upd_t;

  logic [RANK_W-1:0] model_rank [VTX_COUNT];
  logic [RANK_W-1:0] model_acc  [VTX_COUNT];
  logic [DEG_W-1:0]  model_deg  [VTX_COUNT];
  logic [DAMP_W-1:0] model_damp;
  rank_upd_t         pending_ranks[$];
  int                err_cnt;
  int                send_idle_pct;
  int                recv_stall_pct;

  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void predict_item(op_e op, logic [VTX_W-1:0] s, logic [VTX_W-1:0] d);
    logic [63:0] sum;
    rank_upd_t   upd;
    case (op)
      OP_COUNT: if (model_deg[s] != DEG_MAX) model_deg[s] = model_deg[s] + 1'b1;
      OP_GATHER: begin
        if (model_deg[s] != '0) begin
          sum = 64'(model_acc[d]) + 64'(model_rank[s] / 32'(model_deg[s]));
          model_acc[d] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        end
      end
      OP_APPLY: begin
        sum = (64'(model_damp) * 64'(model_acc[d])) >> 16;
        sum = sum + 64'(32'(ONE_Q16) - 32'(model_damp));
        model_rank[d] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        model_acc[d] = '0;
        upd.vid  = d;
        upd.rank = model_rank[d];
        pending_ranks = {pending_ranks, upd};
      end
      default: begin
        model_rank[d] = ONE_Q16;
        model_acc[d]  = '0;
      end
    endcase
  endfunction

  task automatic send_item(op_e op, logic [VTX_W-1:0] s, logic [VTX_W-1:0] d);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    src_vertex_i <= s;
    dst_vertex_i <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_item(op, s, d);
  endtask

  always @(posedge clk_i) begin
    rank_upd_t exp_upd;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_ranks.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("Unexpected result vertex %0d rank %h",
                                      vertex_id_o, rank_value_o);
        end else begin
          exp_upd = pending_ranks.pop_front();
          if (exp_upd.vid !== vertex_id_o || exp_upd.rank !== rank_value_o) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("Mismatch: expected vertex %0d rank %h, got vertex %0d rank %h",
                       exp_upd.vid, exp_upd.rank, vertex_id_o, rank_value_o);
          end
        end
      end
      out_ready_i <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_damping(logic [DAMP_W-1:0] val);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    model_damp = val;
  endtask

  task automatic test_directed();
    send_item(OP_APPLY, 10'd0, 10'd0);
    send_item(OP_GATHER, 10'd5, 10'd6);
    send_item(OP_COUNT, 10'd1023, 10'd0);
    send_item(OP_GATHER, 10'd1023, 10'd1023);
    send_item(OP_APPLY, 10'd0, 10'd1023);
    send_item(OP_COUNT, 10'd0, 10'd1023);
    send_item(OP_GATHER, 10'd0, 10'd1023);
    send_item(OP_INIT, 10'd0, 10'd1023);
    send_item(OP_APPLY, 10'd0, 10'd1023);
    send_item(OP_COUNT, 10'd7, 10'd0);
    send_item(OP_COUNT, 10'd7, 10'd0);
    send_item(OP_COUNT, 10'd7, 10'd0);
    send_item(OP_GATHER, 10'd7, 10'd8);
    send_item(OP_GATHER, 10'd7, 10'd8);
    send_item(OP_APPLY, 10'd7, 10'd8);
    send_item(OP_GATHER, 10'd8, 10'd9);
    send_item(OP_INIT, 10'd8, 10'd9);
    send_item(OP_APPLY, 10'd0, 10'd9);
  endtask

  task automatic test_saturation();
    // One out-edge lets a large source rank pile up in the accumulator.
    send_item(OP_COUNT, 10'd600, 10'd0);
    send_item(OP_INIT, 10'd0, 10'd600);
    for (int i = 0; i < 4; i++) begin
      repeat (20) send_item(OP_GATHER, 10'd600, 10'd600);
      send_item(OP_APPLY, 10'd0, 10'd600);
    end
    repeat (40) send_item(OP_GATHER, 10'd600, 10'd601);
    send_item(OP_APPLY, 10'd0, 10'd601);
  endtask

  task automatic test_random(int n_items);
    logic [VTX_W-1:0] s;
    logic [VTX_W-1:0] d;
    for (int i = 0; i < n_items; i++) begin
      s = VTX_W'($urandom_range(15));
      d = VTX_W'($urandom_range(15));
      if ($urandom_range(9) == 0) s = VTX_W'($urandom);
      if ($urandom_range(9) == 0) d = VTX_W'($urandom);
      case ($urandom_range(9))
        0, 1:    send_item(OP_COUNT, s, d);
        2, 3, 4: send_item(OP_GATHER, s, d);
        5, 6, 7: send_item(OP_APPLY, s, d);
        default: send_item(OP_INIT, s, d);
      endcase
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    opcode_i       = '0;
    src_vertex_i   = '0;
    dst_vertex_i   = '0;
    out_ready_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    err_cnt        = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    model_damp     = DAMP_RESET;
    for (int i = 0; i < VTX_COUNT; i++) begin
      model_rank[i] = ONE_Q16;
      model_acc[i]  = '0;
      model_deg[i]  = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_saturation();
    write_damping(16'hFFFF);
    test_saturation();
    write_damping(16'h0000);
    test_directed();
    write_damping(DAMP_RESET);
    test_random(65);
    send_idle_pct = 47;
    write_damping(16'(($urandom)));
    test_random(65);
    send_idle_pct  = 0;
    recv_stall_pct = 47;
    write_damping(16'hFFFF);
    test_random(65);
    send_idle_pct  = 9;
    recv_stall_pct = 9;
    write_damping(16'h8000);
    test_random(65);
    recv_stall_pct = 0;
    drain_results();

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
